FILE: rtl/lla_pkg.sv
// Package for the least loaded assigner: sizes, payload structs, the cell
// handoff and update structs, and the controller state type.
// No dependencies.
package lla_pkg;

   // Server row size and load width.
   localparam int MAX_SERVERS = 32;
   localparam int LOAD_BITS   = 24;
   localparam int IDX_BITS    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_SERVERS + 1);

   // Field widths of the channels.
   localparam int TIME_BITS = 10;
   localparam int ID_BITS   = 16;
   localparam int NUM_BITS  = 6;
   localparam int CFG_BITS  = 6;
   localparam int OUT_BITS  = 24;

   // Register port.
   localparam int ADDR_BITS = 2;
   localparam int DATA_BITS = 32;
   localparam logic REG_ACTIVE_SERVERS = 1'b0;
   localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(1);

   // Input beat.
   typedef struct packed {
      logic [TIME_BITS-1:0] service_time;
      logic [ID_BITS-1:0]   job_id;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [ID_BITS-1:0]  job_id_out;
      logic [NUM_BITS-1:0] server_number;
      logic [OUT_BITS-1:0] server_load;
   } rsp_type;

   // Best candidate so far, handed from one cell to the next.
   typedef struct packed {
      logic                 have;
      logic [LOAD_BITS-1:0] load;
      logic [IDX_BITS-1:0]  idx;
   } cand_type;

   // Load write, broadcast to all cells.
   typedef struct packed {
      logic                 we;
      logic [IDX_BITS-1:0]  idx;
      logic [LOAD_BITS-1:0] load;
   } upd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

FILE: rtl/least_loaded_assigner.sv
// Top level of the least loaded assigner: register port, controller, the row
// of server cells and the result register. Uses lla_pkg and lla_cell.
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_ready      req_data (req_type)
//   rsp       out         rsp_valid / rsp_ready      rsp_data (rsp_type)
//   csr       in/out      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A job is accepted, then the best candidate ripples through the cell row
// during the scan, and then the new load is written.
// The next job is taken in the cycle after the load write.
// Synchronous reset clears all loads and sets the active count to one.
// The load write waits while the previous result beat is still held.
module least_loaded_assigner
   import lla_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   state_type            state_ff, state_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [CFG_BITS-1:0]  active_ff, active_in;
   logic [CNT_BITS-1:0]  active_cnt;
   req_type              job_ff, job_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   upd_type              upd;
   cand_type             best;
   cand_type             chain [0:MAX_SERVERS];
   logic [LOAD_BITS:0]   sum;
   logic [LOAD_BITS-1:0] sat_load;
   logic                 req_fire;
   logic                 out_free;

   // Register port: single register, always ready.
   assign pready = 1'b1;
   assign prdata = (paddr[1] == REG_ACTIVE_SERVERS) ?
                   DATA_BITS'(active_ff) : '0;

   always_comb begin
      active_in = active_ff;
      if (psel && penable && pwrite && (paddr[1] == REG_ACTIVE_SERVERS)) begin
         active_in = pwdata[CFG_BITS-1:0];
      end
   end

   // Zero counts as one server; counts above the row size are clamped.
   always_comb begin
      if (active_ff == '0) begin
         active_cnt = CNT_BITS'(1);
      end else if (int'(active_ff) > MAX_SERVERS) begin
         active_cnt = CNT_BITS'(MAX_SERVERS);
      end else begin
         active_cnt = CNT_BITS'(active_ff);
      end
   end

   // Row of cells; the first cell sees an empty candidate.
   assign chain[0] = '0;

   for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
      lla_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_BITS'(g)),
         .active_cnt (active_cnt),
         .cand_in    (chain[g]),
         .upd        (upd),
         .cand_out   (chain[g+1])
      );
   end

   assign best = chain[MAX_SERVERS];

   // Saturating add of the service time to the winning load.
   assign sum      = {1'b0, best.load} + (LOAD_BITS+1)'(job_ff.service_time);
   assign sat_load = sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_BITS'(MAX_SERVERS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready = 1'b0;
      upd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            req_ready = 1'b0;
         end
         ST_WRITE: begin
            upd.we   = out_free;
            upd.idx  = best.idx;
            upd.load = sat_load;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Scan counter, job holding register and result register.
   always_comb begin
      cnt_in       = (state_ff == ST_SCAN) ? cnt_ff + IDX_BITS'(1) : '0;
      job_in       = req_fire ? req_data : job_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (upd.we) begin
         rsp_valid_in         = 1'b1;
         rsp_in.job_id_out    = job_ff.job_id;
         rsp_in.server_number = NUM_BITS'(best.idx) + NUM_BITS'(1);
         rsp_in.server_load   = OUT_BITS'(sat_load);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // The chosen server is always one of the active ones.
   a_best_active: assert property (@(posedge clock) disable iff (reset)
      upd.we |-> (best.have && (CNT_BITS'(best.idx) < active_cnt)))
      else $error("chosen server outside the active range");

   // After a job is taken, no other is taken in the next cycle.
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("job accepted during a scan");

   // A new result only ever follows a load write.
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upd.we))
      else $error("result raised without a load write");

   // The reported load never falls below the load it was built on.
   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      upd.we |=> (rsp_ff.server_load >= $past(best.load)))
      else $error("saturating add lost load");
`endif

endmodule

FILE: rtl/lla_cell.sv
// One server cell: holds that server's load and, when active, passes on the smaller of
// its own load and the candidate from the previous cell. Uses lla_pkg.
module lla_cell
   import lla_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  logic [CNT_BITS-1:0] active_cnt,
   input  cand_type            cand_in,
   input  upd_type             upd,
   output cand_type            cand_out
);

   logic [LOAD_BITS-1:0] load_ff, load_in;
   cand_type             cand_ff, cand_in_next;
   logic                 active;

   // A cell takes part only when its index is below the active count.
   assign active = CNT_BITS'(cell_idx) < active_cnt;

   // Keep the earlier candidate on ties so the lowest index wins.
   always_comb begin
      cand_in_next = cand_in;
      if (active && (!cand_in.have || (load_ff < cand_in.load))) begin
         cand_in_next.have = 1'b1;
         cand_in_next.load = load_ff;
         cand_in_next.idx  = cell_idx;
      end
   end

   // Load write when this cell is the one addressed.
   always_comb begin
      load_in = load_ff;
      if (upd.we && (upd.idx == cell_idx)) begin
         load_in = upd.load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   // Candidate register is payload only.
   always_ff @(posedge clock) begin
      cand_ff <= cand_in_next;
   end

   assign cand_out = cand_ff;

endmodule
